[rtl/izh_pkg.sv]
package izh_pkg;

	typedef enum logic [1:0] {
		K_REC = 2'd0,
		K_ENC = 2'd1,
		K_DEC = 2'd2,
		K_CUR = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [31:0] bias;
		logic [30:0]        step;
		logic [30:0]        soc;
		logic [30:0]        stra;
		logic [16:0]        decay;
		logic [16:0]        rise;
		logic [30:0]        kick;
	} cfg_t;

	localparam logic [2:0] REG_BIAS  = 3'd0;
	localparam logic [2:0] REG_STEP  = 3'd1;
	localparam logic [2:0] REG_SOC   = 3'd2;
	localparam logic [2:0] REG_STRA  = 3'd3;
	localparam logic [2:0] REG_DECAY = 3'd4;
	localparam logic [2:0] REG_RISE  = 3'd5;
	localparam logic [2:0] REG_KICK  = 3'd6;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_EMIT = 4;

	// membrane constants in q16.16
	localparam logic signed [63:0] V_REST_NEG = 64'sd3932160;
	localparam logic signed [63:0] V_THR_NEG  = 64'sd1258291;
	localparam logic signed [31:0] V_PEAK     = 32'sd1966080;
	localparam logic signed [31:0] V_RESET    = -32'sd4259840;
	localparam logic signed [63:0] U_JUMP     = 64'sd13107200;
	localparam logic signed [31:0] U_INIT     = 32'sd1966080;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/izh_if.sv]
interface izh_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [5:0]         row_index;
	logic [5:0]         col_index;
	logic signed [31:0] data_value;
	logic               tick_last;

	modport source(output valid, req_type, row_index, col_index, data_value, tick_last,
		input ready);
	modport sink(input valid, req_type, row_index, col_index, data_value, tick_last,
		output ready);
endinterface

interface izh_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         out_channel;
	logic signed [31:0] out_value;
	logic [6:0]         spike_count;
	logic               out_last;

	modport source(output valid, out_channel, out_value, spike_count, out_last,
		input ready);
	modport sink(input valid, out_channel, out_value, spike_count, out_last,
		output ready);
endinterface

[rtl/izh_front.sv]
module izh_front #(
	parameter int NEURONS = 64,
	parameter int OUTPUTS = 4,
	localparam int REC_D = NEURONS * NEURONS,
	localparam int ENC_D = NEURONS * OUTPUTS,
	localparam int QA_W = $clog2(REC_D > ENC_D ? REC_D : ENC_D),
	localparam int QW = 4 + QA_W + 32
) (
	input  logic          clk,
	input  logic          arst_n,
	izh_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output logic [QW-1:0] push_data
);
	import izh_pkg::*;

	kind_t           kind;
	logic            store;
	logic            last;
	logic [QA_W-1:0] addr;
	logic [31:0]     row_w;
	logic [31:0]     col_w;
	logic            v_s1;
	logic [QW-1:0]   data_s1;

	assign row_w = 32'(req.row_index);
	assign col_w = 32'(req.col_index);

	// classify the item and flatten its memory address
	always_comb begin
		kind = kind_t'(req.req_type);
		store = 1'b0;
		last = 1'b0;
		addr = '0;
		case (kind)
			K_REC: begin
				store = (row_w < 32'(NEURONS)) && (col_w < 32'(NEURONS));
				addr = QA_W'(row_w * 32'(NEURONS) + col_w);
			end
			K_ENC: begin
				store = (row_w < 32'(NEURONS)) && (col_w < 32'(OUTPUTS));
				addr = QA_W'(row_w * 32'(OUTPUTS) + col_w);
			end
			K_DEC: begin
				store = (row_w < 32'(OUTPUTS)) && (col_w < 32'(NEURONS));
				addr = QA_W'(row_w * 32'(NEURONS) + col_w);
			end
			default: begin
				store = row_w < 32'(NEURONS);
				last = req.tick_last;
				addr = QA_W'(row_w);
			end
		endcase
	end

	assign req.ready = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			data_s1 <= {kind, store, last, addr, req.data_value};
		end
	end

endmodule

[rtl/izh_queue.sv]
module izh_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = slot_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

[rtl/izh_back.sv]
module izh_back #(
	parameter int NEURONS = 64,
	parameter int OUTPUTS = 4,
	localparam int REC_D = NEURONS * NEURONS,
	localparam int ENC_D = NEURONS * OUTPUTS,
	localparam int QA_W = $clog2(REC_D > ENC_D ? REC_D : ENC_D),
	localparam int QW = 4 + QA_W + 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  izh_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [QW-1:0] pop_data,
	izh_rsp_if.source     rsp
);
	import izh_pkg::*;

	localparam int IDX_W = $clog2(NEURONS);
	localparam int OUT_W = OUTPUTS > 1 ? $clog2(OUTPUTS) : 1;
	localparam int REC_W = $clog2(REC_D);
	localparam int ENC_W = $clog2(ENC_D);
	localparam int JW = $clog2(NEURONS + OUTPUTS);
	localparam int ROW_W = IDX_W > OUT_W ? IDX_W : OUT_W;
	localparam int CLR_W = $clog2(ENC_D + 1);
	localparam int CNT_W = $clog2(NEURONS + 1);
	localparam int ACC_W = 48 + $clog2(NEURONS + OUTPUTS + 2) + 1;
	localparam int N_EMIT = OUTPUTS < MAX_EMIT ? OUTPUTS : MAX_EMIT;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_RUN, S_A_DRAIN,
		S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8,
		S_C_RUN, S_C_DRAIN, S_EMIT
	} state_t;

	state_t state_q;

	// queue entry
	kind_t              pk;
	logic               p_store;
	logic               p_last;
	logic [QA_W-1:0]    p_addr;
	logic signed [31:0] p_data;
	logic               pop_fire;

	// memories
	logic signed [31:0] rec_mem [REC_D];
	logic signed [31:0] enc_mem [ENC_D];
	logic signed [31:0] dec_mem [ENC_D];
	logic signed [31:0] cur_mem [NEURONS];
	logic signed [31:0] ncur_mem [NEURONS];
	logic signed [31:0] v_mem [NEURONS];
	logic signed [31:0] u_mem [NEURONS];
	logic signed [31:0] r_mem [NEURONS];
	logic signed [31:0] h_mem [NEURONS];
	logic signed [31:0] rec_rd, enc_rd, dec_rd, cur_rd, ncur_rd;
	logic signed [31:0] v_rd, u_rd, r_rd, h_rd;
	logic [REC_W-1:0]   rec_ra;
	logic [ENC_W-1:0]   enc_ra;
	logic [ENC_W-1:0]   dec_ra;
	logic [ENC_W-1:0]   dec_wa;
	logic               dec_we;
	logic signed [31:0] dec_wd;
	logic [IDX_W-1:0]   tr_ra;
	logic               st_we;
	logic [IDX_W-1:0]   st_wa;
	logic signed [31:0] v_wd, u_wd, r_wd, h_wd;

	logic signed [31:0] readout_q [OUTPUTS];

	// counters
	logic [IDX_W-1:0] ai_q;
	logic [JW-1:0]    aj_q;
	logic [OUT_W-1:0] ci_q;
	logic [CLR_W-1:0] clr_q;
	logic [CNT_W-1:0] spikes_q;
	logic [1:0]       k_q;
	logic             iss;
	logic             iss_a;
	logic             row_end;

	// mac pipeline
	logic               v_s1, enc_s1, first_s1, last_s1, pha_s1;
	logic [ROW_W-1:0]   row_s1;
	logic signed [31:0] ro_s1;
	logic               v_s2, first_s2, last_s2, pha_s2;
	logic [ROW_W-1:0]   row_s2;
	logic signed [31:0] cur_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [31:0] ro_pick;

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] p_q;
	logic signed [47:0] term;

	// neuron update
	logic signed [31:0] a_q, b_q, w_q, drive_q, nu_q, nv_q, rnew_q;
	logic signed [47:0] rdec_q;
	logic               spk_q;
	logic signed [31:0] t_c, nv_c, h_c;
	logic               spk_c;

	logic               ovalid_q;
	logic [1:0]         och_q;
	logic signed [31:0] oval_q;
	logic               olast_q;

	assign pk = kind_t'(pop_data[QW-1 -: 2]);
	assign p_store = pop_data[QW-3];
	assign p_last = pop_data[QW-4];
	assign p_addr = pop_data[32 +: QA_W];
	assign p_data = $signed(pop_data[31:0]);
	assign pop_ready = state_q == S_IDLE;
	assign pop_fire = pop_valid && pop_ready;

	assign iss_a = state_q == S_A_RUN;
	assign iss = iss_a || (state_q == S_C_RUN);
	assign row_end = iss_a ? (aj_q == JW'(NEURONS + OUTPUTS - 1)) : (aj_q == JW'(NEURONS - 1));

	assign rec_ra = REC_W'(32'(ai_q) * 32'(NEURONS) + 32'(aj_q));
	assign enc_ra = ENC_W'(32'(ai_q) * 32'(OUTPUTS) + 32'(aj_q) - 32'(NEURONS));
	assign dec_ra = ENC_W'(32'(ci_q) * 32'(NEURONS) + 32'(aj_q));
	assign tr_ra = iss ? IDX_W'(aj_q) : ai_q;
	assign ro_pick = readout_q[OUT_W'(32'(aj_q) - 32'(NEURONS))];

	assign term = $signed(p_q[63:16]);

	always_comb begin
		dec_we = 1'b0;
		dec_wa = ENC_W'(p_addr);
		dec_wd = p_data;
		st_we = 1'b0;
		st_wa = ai_q;
		v_wd = nv_q;
		u_wd = nu_q;
		r_wd = rnew_q;
		h_wd = h_c;
		if (state_q == S_CLEAR) begin
			dec_we = 1'b1;
			dec_wa = ENC_W'(clr_q);
			dec_wd = '0;
			st_we = clr_q < CLR_W'(NEURONS);
			st_wa = IDX_W'(clr_q);
			v_wd = '0;
			u_wd = U_INIT;
			r_wd = '0;
			h_wd = '0;
		end else if (pop_fire && pk == K_DEC && p_store) begin
			dec_we = 1'b1;
		end else if (state_q == S_B8) begin
			st_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire && pk == K_REC && p_store) begin
			rec_mem[REC_W'(p_addr)] <= p_data;
		end
		if (pop_fire && pk == K_ENC && p_store) begin
			enc_mem[ENC_W'(p_addr)] <= p_data;
		end
		if (pop_fire && pk == K_CUR && p_store) begin
			cur_mem[IDX_W'(p_addr)] <= p_data;
		end
		if (dec_we) begin
			dec_mem[dec_wa] <= dec_wd;
		end
		if (v_s2 && last_s2 && pha_s2) begin
			ncur_mem[IDX_W'(row_s2)] <= sat32(64'(acc_sum));
		end
		if (st_we) begin
			v_mem[st_wa] <= v_wd;
			u_mem[st_wa] <= u_wd;
			r_mem[st_wa] <= r_wd;
			h_mem[st_wa] <= h_wd;
		end
		rec_rd <= rec_mem[rec_ra];
		enc_rd <= enc_mem[enc_ra];
		dec_rd <= dec_mem[dec_ra];
		cur_rd <= cur_mem[ai_q];
		ncur_rd <= ncur_mem[ai_q];
		v_rd <= v_mem[ai_q];
		u_rd <= u_mem[ai_q];
		r_rd <= r_mem[tr_ra];
		h_rd <= h_mem[ai_q];
	end

	always_comb begin
		case (state_q)
			S_B2: begin
				mul_a = a_q;
				mul_b = b_q;
			end
			S_B3: begin
				mul_a = $signed({1'b0, cfg.stra});
				mul_b = w_q;
			end
			S_B4: begin
				mul_a = $signed({1'b0, cfg.soc});
				mul_b = drive_q;
			end
			S_B5: begin
				mul_a = $signed(32'(cfg.decay));
				mul_b = r_rd;
			end
			S_B6: begin
				mul_a = h_rd;
				mul_b = $signed({1'b0, cfg.step});
			end
			S_B7: begin
				mul_a = $signed(32'(cfg.rise));
				mul_b = h_rd;
			end
			default: begin
				mul_a = enc_s1 ? enc_rd : (pha_s1 ? rec_rd : dec_rd);
				mul_b = enc_s1 ? ro_s1 : r_rd;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	// accumulate stage: a recurrent row opens with bias plus external current, a readout row with zero
	always_comb begin
		if (first_s2) begin
			acc_base = pha_s2 ? (ACC_W'(cfg.bias) + ACC_W'(cur_s2)) : '0;
		end else begin
			acc_base = acc_q;
		end
		acc_sum = acc_base + ACC_W'(term);
	end

	always_comb begin
		t_c = sat32(64'(term));
		nv_c = sat32(64'(v_rd) + 64'(term));
		spk_c = nv_c >= V_PEAK;
		h_c = sat32(64'(term) + (spk_q ? 64'(cfg.kick) : 64'sd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ai_q <= '0;
			aj_q <= '0;
			ci_q <= '0;
			spikes_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ovalid_q <= 1'b0;
			for (int o = 0; o < OUTPUTS; o++) begin
				readout_q[o] <= '0;
			end
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			if (v_s2 && last_s2 && !pha_s2) begin
				readout_q[OUT_W'(row_s2)] <= sat32(64'(acc_sum));
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(ENC_D - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop_fire && pk == K_CUR && p_last) begin
						state_q <= S_A_RUN;
						ai_q <= '0;
						aj_q <= '0;
						spikes_q <= '0;
					end
				end
				S_A_RUN: begin
					if (row_end) begin
						aj_q <= '0;
						if (ai_q == IDX_W'(NEURONS - 1)) begin
							ai_q <= '0;
							state_q <= S_A_DRAIN;
						end else begin
							ai_q <= ai_q + 1'b1;
						end
					end else begin
						aj_q <= aj_q + 1'b1;
					end
				end
				S_A_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_B0;
					end
				end
				S_B0: state_q <= S_B1;
				S_B1: state_q <= S_B2;
				S_B2: state_q <= S_B3;
				S_B3: state_q <= S_B4;
				S_B4: state_q <= S_B5;
				S_B5: state_q <= S_B6;
				S_B6: state_q <= S_B7;
				S_B7: state_q <= S_B8;
				S_B8: begin
					if (spk_q) begin
						spikes_q <= spikes_q + 1'b1;
					end
					if (ai_q == IDX_W'(NEURONS - 1)) begin
						ai_q <= '0;
						aj_q <= '0;
						ci_q <= '0;
						state_q <= S_C_RUN;
					end else begin
						ai_q <= ai_q + 1'b1;
						state_q <= S_B0;
					end
				end
				S_C_RUN: begin
					if (row_end) begin
						aj_q <= '0;
						if (ci_q == OUT_W'(OUTPUTS - 1)) begin
							state_q <= S_C_DRAIN;
						end else begin
							ci_q <= ci_q + 1'b1;
						end
					end else begin
						aj_q <= aj_q + 1'b1;
					end
				end
				S_C_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_EMIT;
						ovalid_q <= 1'b1;
						k_q <= '0;
						och_q <= '0;
						oval_q <= readout_q[0];
						olast_q <= N_EMIT == 1;
					end
				end
				S_EMIT: begin
					if (rsp.ready) begin
						if (olast_q) begin
							ovalid_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							och_q <= k_q + 1'b1;
							oval_q <= readout_q[OUT_W'(k_q + 1'b1)];
							olast_q <= (k_q + 1'b1) == 2'(N_EMIT - 1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers of the pipeline and the neuron update
	always_ff @(posedge clk) begin
		enc_s1 <= aj_q >= JW'(NEURONS);
		first_s1 <= aj_q == '0;
		last_s1 <= row_end;
		pha_s1 <= iss_a;
		row_s1 <= iss_a ? ROW_W'(ai_q) : ROW_W'(ci_q);
		ro_s1 <= ro_pick;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		pha_s2 <= pha_s1;
		row_s2 <= row_s1;
		cur_s2 <= cur_rd;
		if (v_s2) begin
			acc_q <= acc_sum;
		end
		case (state_q)
			S_B1: begin
				a_q <= sat32(64'(v_rd) + V_REST_NEG);
				b_q <= sat32(64'(v_rd) + V_THR_NEG);
				w_q <= sat32(-64'sd2 * (64'(v_rd) + V_REST_NEG) - 64'(u_rd));
			end
			S_B3: begin
				drive_q <= sat32(((64'(t_c) * 64'sd5) >>> 1) - 64'(u_rd) + 64'(ncur_rd));
			end
			S_B4: begin
				nu_q <= sat32(64'(u_rd) + 64'(term));
			end
			S_B5: begin
				spk_q <= spk_c;
				nv_q <= spk_c ? V_RESET : nv_c;
				nu_q <= spk_c ? sat32(64'(nu_q) + U_JUMP) : nu_q;
			end
			S_B6: begin
				rdec_q <= term;
			end
			S_B7: begin
				rnew_q <= sat32(64'(rdec_q) + 64'(term));
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = ovalid_q;
	assign rsp.out_channel = och_q;
	assign rsp.out_value = oval_q;
	assign rsp.out_last = olast_q;
	assign rsp.spike_count = (32'(spikes_q) > 32'd127) ? 7'd127 : 7'(spikes_q);

endmodule

[rtl/izhikevich_neuron_network_step_unit.sv]
// load and current items: one per cycle through the front stage and queue
// while the queue has room; a tick runs a recurrent and encoder mac pass,
// a neuron update pass and a readout mac pass on the single shared multiplier
// results follow at one per cycle while the receiver is ready; the queue
// takes items while a tick runs; after reset a clearing pass sets neuron
// state and decoder weights; no item is taken from the queue until it ends
module izhikevich_neuron_network_step_unit #(
	parameter int NEURONS = 64,
	parameter int OUTPUTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	izh_req_if.sink     req,
	izh_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import izh_pkg::*;

	localparam int REC_D = NEURONS * NEURONS;
	localparam int ENC_D = NEURONS * OUTPUTS;
	localparam int QA_W = $clog2(REC_D > ENC_D ? REC_D : ENC_D);
	localparam int QW = 4 + QA_W + 32;

	cfg_t          cfg_q;
	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0] push_data, pop_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias <= '0;
			cfg_q.step <= 31'd3277;
			cfg_q.soc <= 31'd13;
			cfg_q.stra <= 31'd33;
			cfg_q.decay <= 17'd65372;
			cfg_q.rise <= 17'd63898;
			cfg_q.kick <= 31'd1638;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_BIAS:  cfg_q.bias <= $signed(pwdata);
				REG_STEP:  cfg_q.step <= pwdata[30:0];
				REG_SOC:   cfg_q.soc <= pwdata[30:0];
				REG_STRA:  cfg_q.stra <= pwdata[30:0];
				REG_DECAY: cfg_q.decay <= pwdata[16:0];
				REG_RISE:  cfg_q.rise <= pwdata[16:0];
				REG_KICK:  cfg_q.kick <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_BIAS:  prdata = cfg_q.bias;
			REG_STEP:  prdata = 32'(cfg_q.step);
			REG_SOC:   prdata = 32'(cfg_q.soc);
			REG_STRA:  prdata = 32'(cfg_q.stra);
			REG_DECAY: prdata = 32'(cfg_q.decay);
			REG_RISE:  prdata = 32'(cfg_q.rise);
			REG_KICK:  prdata = 32'(cfg_q.kick);
			default:   prdata = '0;
		endcase
	end

	izh_front #(.NEURONS(NEURONS), .OUTPUTS(OUTPUTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	izh_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	izh_back #(.NEURONS(NEURONS), .OUTPUTS(OUTPUTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

[rtl/izh_checker.sv]
module izh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] out_channel,
	input logic [6:0] spike_count,
	input logic       out_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result shown during reset");

	// results of one tick come back to back with rising channel
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !out_last |=>
		rsp_valid && out_channel == $past(out_channel) + 2'd1)
		else $error("channel sequence broken");

	a_spk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !out_last |=> spike_count == $past(spike_count))
		else $error("spike count changed within a tick");

endmodule

bind izhikevich_neuron_network_step_unit izh_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_channel (rsp.out_channel),
	.spike_count (rsp.spike_count),
	.out_last    (rsp.out_last)
);

[dv/tb_izhikevich_neuron_network_step_unit.sv]
module tb_izhikevich_neuron_network_step_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import izh_pkg::*;

	localparam int N_NEUR = 64;
	localparam int N_OUT = 4;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic [1:0]         channel;
		logic signed [31:0] value;
		logic [6:0]         spikes;
		logic               last;
	} readout_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	izh_req_if req();
	izh_rsp_if rsp();

	izhikevich_neuron_network_step_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// network shadow state
	int  mem_v[N_NEUR], mem_u[N_NEUR], decay_tr[N_NEUR], rise_tr[N_NEUR];
	int  ext_cur[N_NEUR], net_cur[N_NEUR];
	int  w_rec[N_NEUR*N_NEUR], w_enc[N_NEUR*N_OUT], w_dec[N_OUT*N_NEUR];
	int  readout_sum[N_OUT];
	longint c_bias, c_step, c_soc, c_stra, c_decay, c_rise, c_kick;

	readout_t pending_readouts[$];
	int errors = 0;
	int n_checked = 0;
	int n_ticks = 0;
	int n_items = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic int sat(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic void network_tick();
		longint acc, v, u, t, h;
		int drive, w, nv, nu, spikes;
		bit spk;
		readout_t r;
		spikes = 0;
		for (int i = 0; i < N_NEUR; i++) begin
			acc = c_bias + ext_cur[i];
			for (int j = 0; j < N_NEUR; j++) acc += qmul(w_rec[i*N_NEUR+j], decay_tr[j]);
			for (int j = 0; j < N_OUT; j++) acc += qmul(w_enc[i*N_OUT+j], readout_sum[j]);
			net_cur[i] = sat(acc);
		end
		for (int i = 0; i < N_NEUR; i++) begin
			v = mem_v[i];
			u = mem_u[i];
			t = sat(qmul(sat(v + 3932160), sat(v + 1258291)));
			drive = sat(((t * 5) >>> 1) - u + net_cur[i]);
			w = sat(-2 * (v + 3932160) - u);
			nv = sat(v + qmul(c_soc, drive));
			nu = sat(u + qmul(c_stra, w));
			h = rise_tr[i];
			spk = (nv >= 1966080);
			if (spk) begin
				spikes++;
				nv = -4259840;
				nu = sat(longint'(nu) + 13107200);
			end
			mem_v[i] = nv;
			mem_u[i] = nu;
			decay_tr[i] = sat(qmul(c_decay, decay_tr[i]) + qmul(h, c_step));
			rise_tr[i] = sat(qmul(c_rise, h) + (spk ? c_kick : 0));
		end
		for (int k = 0; k < N_OUT; k++) begin
			acc = 0;
			for (int j = 0; j < N_NEUR; j++) acc += qmul(w_dec[k*N_NEUR+j], decay_tr[j]);
			readout_sum[k] = sat(acc);
		end
		for (int k = 0; k < N_OUT; k++) begin
			r.channel = k[1:0];
			r.value = readout_sum[k];
			r.spikes = (spikes > 127) ? 7'd127 : spikes[6:0];
			r.last = (k == N_OUT - 1);
			pending_readouts.push_back(r);
		end
		n_ticks++;
	endfunction

	function automatic void apply_item(kind_t kind, int row, int col, int data, bit last);
		case (kind)
			K_REC: w_rec[row*N_NEUR+col] = data;
			K_ENC: if (col < N_OUT) w_enc[row*N_OUT+col] = data;
			K_DEC: if (row < N_OUT) w_dec[row*N_NEUR+col] = data;
			K_CUR: begin
				ext_cur[row] = data;
				if (last) network_tick();
			end
		endcase
	endfunction

	task automatic send_item(kind_t kind, int row, int col, int data, bit last);
		if ($urandom_range(99) < snd_idle) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.row_index <= row[5:0];
		req.col_index <= col[5:0];
		req.data_value <= data;
		req.tick_last <= last;
		do @(posedge clk); while (!req.ready);
		apply_item(kind, row, col, data, last);
		n_items++;
	endtask

	task automatic go_quiet();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		go_quiet();
		while (pending_readouts.size() != 0) @(posedge clk);
		// loads give no readout and may still be in flight
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_BIAS:  c_bias = longint'($signed(val));
			REG_STEP:  c_step = val[30:0];
			REG_SOC:   c_soc = val[30:0];
			REG_STRA:  c_stra = val[30:0];
			REG_DECAY: c_decay = val[16:0];
			REG_RISE:  c_rise = val[16:0];
			REG_KICK:  c_kick = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int bias, int step, int soc, int stra, int dec, int ris, int kick);
		write_reg(REG_BIAS, bias);
		write_reg(REG_STEP, step);
		write_reg(REG_SOC, soc);
		write_reg(REG_STRA, stra);
		write_reg(REG_DECAY, dec);
		write_reg(REG_RISE, ris);
		write_reg(REG_KICK, kick);
	endtask

	function automatic int rand_value(int span);
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(2 * span) - span;
		endcase
	endfunction

	function automatic int small_weight();
		return $urandom_range(8192) - 4096;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	// readout side: checks each item and makes its own ready pattern
	always @(posedge clk) begin
		readout_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_readouts.size() == 0) begin
				report_mismatch("unexpected readout channel", rsp.out_channel, -1);
			end else begin
				want = pending_readouts.pop_front();
				if (rsp.out_channel !== want.channel)
					report_mismatch("out_channel", rsp.out_channel, want.channel);
				if (rsp.out_value !== want.value)
					report_mismatch("out_value", rsp.out_value, want.value);
				if (rsp.spike_count !== want.spikes)
					report_mismatch("spike_count", rsp.spike_count, want.spikes);
				if (rsp.out_last !== want.last)
					report_mismatch("out_last", rsp.out_last, want.last);
				n_checked++;
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("izhikevich_neuron_network_step_unit test failed");
			$finish;
		end
	end

	// every weight and current gets a value before the first tick reads them
	task automatic test_fill_memories();
		for (int i = 0; i < N_NEUR; i++)
			for (int j = 0; j < N_NEUR; j++) send_item(K_REC, i, j, small_weight(), $urandom_range(1));
		for (int i = 0; i < N_NEUR; i++)
			for (int j = 0; j < N_OUT; j++) send_item(K_ENC, i, j, small_weight(), 1'b0);
		for (int i = 0; i < N_OUT; i++)
			for (int j = 0; j < N_NEUR; j++) send_item(K_DEC, i, j, small_weight() * 4, 1'b0);
		for (int i = 0; i < N_NEUR; i++) send_item(K_CUR, i, 0, $urandom_range(1 << 20), 1'b0);
	endtask

	task automatic test_directed();
		send_item(K_CUR, 0, 0, 32'sd700000, 1'b1);
		send_item(K_REC, 63, 63, 32'h7fffffff, 1'b1);
		send_item(K_REC, 0, 0, 32'h80000000, 1'b0);
		send_item(K_ENC, 63, 3, 32'h7fffffff, 1'b0);
		send_item(K_ENC, 5, 47, 32'sd12345, 1'b1);
		send_item(K_DEC, 3, 63, 32'h80000000, 1'b0);
		send_item(K_DEC, 63, 1, 32'sd999, 1'b0);
		send_item(K_DEC, 2, 0, 32'h7fffffff, 1'b1);
		send_item(K_CUR, 63, 63, 32'h7fffffff, 1'b0);
		send_item(K_CUR, 62, 0, 32'h80000000, 1'b0);
		// strong drive across many neurons to make them spike
		for (int i = 0; i < 8; i++) send_item(K_CUR, i, i, 32'sd40000000, 1'b0);
		send_item(K_CUR, 8, 0, 32'sd0, 1'b1);
		send_item(K_CUR, 9, 0, 32'sd65536, 1'b1);
		send_item(K_CUR, 10, 0, -32'sd65536, 1'b1);
		wait_drained();
	endtask

	task automatic random_items(int count);
		kind_t kind;
		for (int n = 0; n < count; n++) begin
			kind = kind_t'($urandom_range(9) < 6 ? K_CUR : $urandom_range(2));
			if (kind == K_CUR)
				send_item(kind, $urandom_range(63), $urandom_range(63),
					rand_value(1 << 22), $urandom_range(5) == 0);
			else
				send_item(kind, $urandom_range(63), $urandom_range(63),
					rand_value(1 << 14), $urandom_range(1));
		end
	endtask

	task automatic test_random_phases();
		snd_idle = 30; rcv_idle = 64;
		random_items(70);
		wait_drained();
		set_config(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 65536, 32'h7fffffff);
		snd_idle = 64; rcv_idle = 30;
		random_items(35);
		wait_drained();
		set_config(32'h80000000, 0, 0, 0, 65536, 0, 0);
		random_items(35);
		wait_drained();
		set_config(32'sd131072, 6554, 655, 1311, 62000, 60000, 8000);
		snd_idle = 0; rcv_idle = 0;
		random_items(70);
		wait_drained();
	endtask

	// readout held off while ticks keep arriving
	task automatic test_backpressure();
		hold_left = 12000;
		for (int n = 0; n < 6; n++) send_item(K_CUR, n, 0, rand_value(1 << 22), 1'b1);
		random_items(10);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.req_type = K_REC; req.row_index = '0; req.col_index = '0;
		req.data_value = '0; req.tick_last = 1'b0;
		rsp.ready = 1'b0;
		c_bias = 0; c_step = 3277; c_soc = 13; c_stra = 33;
		c_decay = 65372; c_rise = 63898; c_kick = 1638;
		for (int i = 0; i < N_NEUR; i++) begin
			mem_v[i] = 0; mem_u[i] = 1966080; decay_tr[i] = 0; rise_tr[i] = 0;
		end
		foreach (readout_sum[k]) readout_sum[k] = 0;
		foreach (w_dec[k]) w_dec[k] = 0;
		snd_idle = 30; rcv_idle = 64;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_memories();
		test_directed();
		test_random_phases();
		test_backpressure();
		go_quiet();
		repeat (200) @(posedge clk);
		$display("covered %0d items, %0d network ticks, %0d readouts checked", n_items, n_ticks,
			n_checked);
		$display("register settings: reset values, upper and lower extremes, one mid setting");
		if (errors == 0 && pending_readouts.size() == 0) begin
			$display("izhikevich_neuron_network_step_unit test passed");
		end else begin
			if (pending_readouts.size() != 0)
				$display("%0d readouts never arrived", pending_readouts.size());
			$display("izhikevich_neuron_network_step_unit test failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/izh_pkg.sv
rtl/izh_if.sv
rtl/izh_front.sv
rtl/izh_queue.sv
rtl/izh_back.sv
rtl/izhikevich_neuron_network_step_unit.sv
rtl/izh_checker.sv
dv/tb_izhikevich_neuron_network_step_unit.sv
